[sv/bpsc_pkg.sv]
// ----------------------------------------------------------------------------
// bpsc_pkg
// Shared types and constants of the bit-packed stream compare block.
// ----------------------------------------------------------------------------
package bpsc_pkg;

   localparam int VALUE_BITS     = 16;
   localparam int BYTE_BITS      = 8;
   localparam int BUFFER_BITS    = 23;
   localparam int PENDING_BITS   = 5;
   localparam int COUNT_BITS     = 16;
   localparam int WIDTH_CFG_BITS = 5;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [WIDTH_CFG_BITS-1:0] VALUE_BITS_MAX = WIDTH_CFG_BITS'(VALUE_BITS);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VALUE_BITS    = 1'b0,
      CSR_COMPARE_BYTES = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BUFFER_BITS-1:0]  buffer;
      logic [PENDING_BITS-1:0] pending;
      logic [COUNT_BITS-1:0]   count;
      logic                    diff;
   } stream_state_type;

   typedef struct packed {
      logic [WIDTH_CFG_BITS-1:0] value_bits;
      logic [COUNT_BITS-1:0]     compare_bytes;
   } cfg_type;

endpackage

[sv/bpsc_interfaces.sv]
// ----------------------------------------------------------------------------
// bpsc request and response channels
// Valid/ready channels carrying the packed-compare request and its result.
// ----------------------------------------------------------------------------
interface bpsc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] value;
   logic [7:0]  ref_byte_first;
   logic [7:0]  ref_byte_second;
   logic        last_value;

   modport source (output valid, value, ref_byte_first, ref_byte_second, last_value,
                   input ready);
   modport sink   (input valid, value, ref_byte_first, ref_byte_second, last_value,
                   output ready);
endinterface

interface bpsc_rsp_if;
   logic valid;
   logic ready;
   logic mismatch;

   modport source (output valid, mismatch, input ready);
   modport sink   (input valid, mismatch, output ready);
endinterface

[sv/bpsc_step.sv]
// ----------------------------------------------------------------------------
// bpsc_step
// Appends one value to the bit stream and takes up to two whole bytes,
// comparing each against its reference byte within the compare limit.
// ----------------------------------------------------------------------------
module bpsc_step (
   input  bpsc_pkg::stream_state_type state,
   input  bpsc_pkg::cfg_type          cfg,
   input  logic [15:0]                value,
   input  logic [7:0]                 ref_byte_first,
   input  logic [7:0]                 ref_byte_second,
   output bpsc_pkg::stream_state_type state_next
);
   import bpsc_pkg::*;

   function automatic stream_state_type take_byte(stream_state_type s,
                                                  logic [BYTE_BITS-1:0] ref_b,
                                                  logic [COUNT_BITS-1:0] limit);
      stream_state_type        t;
      logic [BYTE_BITS-1:0]    byte_v;
      logic [PENDING_BITS-1:0] rest;
      t = s;
      if (s.pending >= PENDING_BITS'(BYTE_BITS)) begin
         rest      = s.pending - PENDING_BITS'(BYTE_BITS);
         byte_v    = BYTE_BITS'(s.buffer >> rest);
         t.pending = rest;
         t.buffer  = s.buffer & ((BUFFER_BITS'(1) << rest) - BUFFER_BITS'(1));
         // bytes past the limit still leave the stream
         if (s.count < limit) begin
            if (byte_v != ref_b) begin
               t.diff = 1'b1;
            end
            t.count = s.count + COUNT_BITS'(1);
         end
      end
      return t;
   endfunction

   logic [WIDTH_CFG_BITS-1:0] width;
   logic [VALUE_BITS-1:0]     mask;
   logic [VALUE_BITS-1:0]     masked;
   stream_state_type          appended;
   stream_state_type          after_first;

   always_comb begin
      width  = (cfg.value_bits > VALUE_BITS_MAX) ? VALUE_BITS_MAX : cfg.value_bits;
      mask   = VALUE_BITS'((17'd1 << width) - 17'd1);
      masked = value & mask;

      appended         = state;
      appended.buffer  = BUFFER_BITS'(state.buffer << width)
                       | BUFFER_BITS'(masked);
      appended.pending = state.pending + width;

      after_first = take_byte(appended, ref_byte_first, cfg.compare_bytes);
      state_next  = take_byte(after_first, ref_byte_second, cfg.compare_bytes);
   end

endmodule

[sv/bit_packed_stream_compare_top.sv]
// ----------------------------------------------------------------------------
// bit_packed_stream_compare_top
// Path: request accept into the input register, then the stream update into the
// stream state, or on the last value into the result register. Throughput: one
// request per cycle, unless a last value waits on a result not yet taken.
// Reset (synchronous): stream state cleared, value_bits 16, compare_bytes 65535.
// ----------------------------------------------------------------------------
module bit_packed_stream_compare_top (
   input  logic                               clock,
   input  logic                               reset,
   bpsc_req_if.sink                           req,
   bpsc_rsp_if.source                         rsp,
   input  logic                               csr_write_enable,
   input  logic [bpsc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bpsc_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import bpsc_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   stream_state_type state_ff, state_in, state_step;

   logic       in_valid_ff, in_valid_in;
   logic [15:0] in_value_ff;
   logic [7:0]  in_first_ff, in_second_ff;
   logic        in_last_ff;
   logic        out_valid_ff, out_valid_in;
   logic        out_mismatch_ff, out_mismatch_in;
   logic        proc_fire;

   // a registered request with no result never waits on the response side
   assign proc_fire = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || proc_fire;

   bpsc_step u_step (
      .state           (state_ff),
      .cfg             (cfg_ff),
      .value           (in_value_ff),
      .ref_byte_first  (in_first_ff),
      .ref_byte_second (in_second_ff),
      .state_next      (state_step)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_VALUE_BITS:    cfg_in.value_bits    = csr_write_data[WIDTH_CFG_BITS-1:0];
            CSR_COMPARE_BYTES: cfg_in.compare_bytes = csr_write_data[COUNT_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in     = in_valid_ff;
      state_in        = state_ff;
      out_valid_in    = out_valid_ff;
      out_mismatch_in = out_mismatch_ff;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (proc_fire) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            out_valid_in    = 1'b1;
            out_mismatch_in = state_step.diff;
            state_in        = '0;
         end else begin
            state_in = state_step;
         end
      end
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.value_bits    <= VALUE_BITS_MAX;
         cfg_ff.compare_bytes <= '1;
         state_ff             <= '0;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_value_ff  <= req.value;
         in_first_ff  <= req.ref_byte_first;
         in_second_ff <= req.ref_byte_second;
         in_last_ff   <= req.last_value;
      end
      out_mismatch_ff <= out_mismatch_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.mismatch = out_mismatch_ff;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench for bit_packed_stream_compare_top
// Streams of values with matching, corrupted or random reference bytes run
// through several width and compare-limit settings under varying idling. A
// bit-level packer predicts the mismatch flag of every stream end.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bpsc_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 3;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1600;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum {REFS_CLEAN, REFS_FLIP, REFS_NOISE} ref_kind_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [BYTE_BITS-1:0]  ref_first;
      logic [BYTE_BITS-1:0]  ref_second;
      logic                  last;
   } compare_request_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   bpsc_req_if req_if ();
   bpsc_rsp_if rsp_if ();

   bit_packed_stream_compare_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   compare_request_type request_queue[$];
   logic                expected_mismatch[$];
   compare_request_type next_request;

   cfg_type          csr_shadow;
   stream_state_type packer_state;   // stimulus side, used to build matching refs
   stream_state_type model_state;    // prediction side, advanced on accepted requests

   int unsigned queued_requests   = 0;
   int unsigned accepted_requests = 0;
   int unsigned results_checked   = 0;
   int unsigned results_differing = 0;
   int unsigned config_settings   = 0;
   int unsigned error_count       = 0;
   int unsigned cycle_count       = 0;
   int unsigned send_idle_pct     = 0;
   int unsigned stall_pct         = 0;

   always #(CLOCK_HALF) clock = ~clock;

   // append the value to the bit stream, peel off up to two whole bytes
   function automatic void pack_value(inout stream_state_type s, input cfg_type c,
                                      input logic [VALUE_BITS-1:0] value,
                                      output logic [1:0][BYTE_BITS-1:0] got,
                                      output int unsigned n_got);
      int unsigned width;
      logic [31:0] stream_bits;
      int unsigned held;
      int k;
      width = (c.value_bits > VALUE_BITS_MAX) ? VALUE_BITS : int'(c.value_bits);
      stream_bits = ({9'b0, s.buffer} << width) | (32'(value) & ((32'd1 << width) - 1));
      stream_bits &= (32'd1 << BUFFER_BITS) - 1;
      held = s.pending + width;
      got = '0;
      n_got = 0;
      for (k = 0; k < 2; k++) begin
         if (held >= BYTE_BITS) begin
            got[k] = BYTE_BITS'(stream_bits >> (held - BYTE_BITS));
            held -= BYTE_BITS;
            stream_bits &= (32'd1 << held) - 1;
            n_got++;
         end
      end
      s.buffer  = stream_bits[BUFFER_BITS-1:0];
      s.pending = held[PENDING_BITS-1:0];
   endfunction

   function automatic void predict_request(compare_request_type rq);
      logic [1:0][BYTE_BITS-1:0] got;
      int unsigned n_got;
      logic [BYTE_BITS-1:0] want;
      pack_value(model_state, csr_shadow, rq.value, got, n_got);
      for (int k = 0; k < n_got; k++) begin
         want = (k == 0) ? rq.ref_first : rq.ref_second;
         // bytes past the compare limit are consumed but not checked
         if (model_state.count < csr_shadow.compare_bytes) begin
            if (got[k] != want) model_state.diff = 1'b1;
            model_state.count++;
         end
      end
      if (rq.last) begin
         expected_mismatch.push_back(model_state.diff);
         model_state = '0;
      end
   endfunction

   function automatic void add_value(logic [VALUE_BITS-1:0] value, logic last,
                                     ref_kind_type kind);
      logic [1:0][BYTE_BITS-1:0] got;
      int unsigned n_got;
      int unsigned k;
      compare_request_type rq;
      pack_value(packer_state, csr_shadow, value, got, n_got);
      rq.value      = value;
      rq.last       = last;
      rq.ref_first  = (n_got > 0) ? got[0] : 8'($urandom);
      rq.ref_second = (n_got > 1) ? got[1] : 8'($urandom);
      if (kind == REFS_FLIP && n_got > 0) begin
         k = $urandom_range(0, n_got - 1);
         if (k == 0) rq.ref_first[$urandom_range(0, 7)] ^= 1'b1;
         else rq.ref_second[$urandom_range(0, 7)] ^= 1'b1;
      end else if (kind == REFS_NOISE) begin
         rq.ref_first  = 8'($urandom);
         rq.ref_second = 8'($urandom);
      end
      if (last) packer_state = '0;
      request_queue.push_back(rq);
      queued_requests++;
   endfunction

   task automatic wait_idle();
      while (accepted_requests != queued_requests || expected_mismatch.size() != 0)
         @(posedge clock);
      // a request without last_value may still be in the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_VALUE_BITS) csr_shadow.value_bits = data[WIDTH_CFG_BITS-1:0];
      else csr_shadow.compare_bytes = data;
   endtask

   task automatic set_config(logic [WIDTH_CFG_BITS-1:0] vb, logic [COUNT_BITS-1:0] cb);
      wait_idle();
      write_csr(CSR_VALUE_BITS, {11'($urandom), vb});
      write_csr(CSR_COMPARE_BYTES, cb);
      config_settings++;
   endtask

   task automatic set_idle(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 73;
            stall_pct     = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = 73;
         end
         default: begin
            send_idle_pct = 37;
            stall_pct     = 37;
         end
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_request = request_queue.pop_front();
            req_if.valid           <= 1'b1;
            req_if.value           <= next_request.value;
            req_if.ref_byte_first  <= next_request.ref_first;
            req_if.ref_byte_second <= next_request.ref_second;
            req_if.last_value      <= next_request.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // monitor: check results, then predict from accepted requests
   always @(posedge clock) begin : monitor
      logic want;
      compare_request_type rq;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (rsp_if.mismatch === 1'b1) results_differing++;
            if (expected_mismatch.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got mismatch %0b",
                        $time, rsp_if.mismatch);
            end else begin
               want = expected_mismatch.pop_front();
               if (rsp_if.mismatch !== want) begin
                  error_count++;
                  $display("%0t: mismatch flag expected %0b, got %0b",
                           $time, want, rsp_if.mismatch);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            accepted_requests++;
            rq.value      = req_if.value;
            rq.ref_first  = req_if.ref_byte_first;
            rq.ref_second = req_if.ref_byte_second;
            rq.last       = req_if.last_value;
            predict_request(rq);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding",
                  $time, expected_mismatch.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned random_sent;
      int unsigned budget;
      int unsigned len;
      int unsigned flip_at;
      int unsigned phase;
      int unsigned sel;
      ref_kind_type kind;
      logic [WIDTH_CFG_BITS-1:0] vb;
      logic [COUNT_BITS-1:0] cb;

      req_if.valid           = 1'b0;
      req_if.value           = '0;
      req_if.ref_byte_first  = '0;
      req_if.ref_byte_second = '0;
      req_if.last_value      = 1'b0;
      rsp_if.ready           = 1'b0;
      csr_write_enable       = 1'b0;
      csr_index              = CSR_VALUE_BITS;
      csr_write_data         = '0;
      csr_shadow.value_bits    = VALUE_BITS_MAX;
      csr_shadow.compare_bytes = '1;
      packer_state = '0;
      model_state  = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full width, two bytes per value
      add_value(16'hFFFF, 1'b1, REFS_CLEAN);
      add_value(16'h0000, 1'b0, REFS_CLEAN);
      add_value(16'hA5C3, 1'b1, REFS_FLIP);
      add_value(16'h8001, 1'b1, REFS_NOISE);

      // one bit per value, ninth bit is a trailing partial byte
      set_config(5'd1, 16'hFFFF);
      for (int j = 0; j < 9; j++) add_value(16'($urandom), j == 8, REFS_CLEAN);

      // zero width packs nothing
      set_config(5'd0, 16'd3);
      add_value(16'hFFFF, 1'b0, REFS_NOISE);
      add_value(16'h1234, 1'b1, REFS_NOISE);

      // oversized width acts as sixteen, nothing compared at limit zero
      set_config(5'd31, 16'd0);
      add_value(16'hFFFF, 1'b0, REFS_NOISE);
      add_value(16'h5A5A, 1'b1, REFS_NOISE);

      // limit of one: second byte corrupted but beyond the limit
      set_config(5'd3, 16'd1);
      for (int j = 0; j < 6; j++)
         add_value(16'($urandom), j == 5, (j == 5) ? REFS_FLIP : REFS_CLEAN);

      // width change in the middle of a stream
      set_config(5'd5, 16'hFFFF);
      for (int j = 0; j < 3; j++) add_value(16'($urandom), 1'b0, REFS_CLEAN);
      set_config(5'd13, 16'hFFFF);
      add_value(16'($urandom), 1'b1, REFS_FLIP);

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel < 7) vb = WIDTH_CFG_BITS'($urandom_range(1, 16));
         else if (sel == 7) vb = 5'd0;
         else vb = WIDTH_CFG_BITS'($urandom_range(17, 31));
         sel = $urandom_range(0, 9);
         if (sel == 0) cb = 16'd0;
         else if (sel == 1) cb = 16'd1;
         else if (sel < 6) cb = COUNT_BITS'($urandom_range(2, 24));
         else if (sel < 8) cb = 16'hFFFF;
         else cb = COUNT_BITS'($urandom_range(0, 65535));
         set_config(vb, cb);
         set_idle(idle_mode_type'(phase % 4));
         // the final stream of a phase may be cut short and carry over
         budget = $urandom_range(50, 150);
         while (budget > 0) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) len = 1;
            else if (sel < 15) len = $urandom_range(1, 12);
            else len = $urandom_range(13, 40);
            sel = $urandom_range(0, 19);
            if (sel < 10) kind = REFS_CLEAN;
            else if (sel < 17) kind = REFS_FLIP;
            else kind = REFS_NOISE;
            flip_at = $urandom_range(0, len - 1);
            for (int j = 0; j < len && budget > 0; j++) begin
               add_value(16'($urandom), j == len - 1,
                         (kind == REFS_NOISE) ? REFS_NOISE :
                         (kind == REFS_FLIP && j == flip_at) ? REFS_FLIP : REFS_CLEAN);
               budget--;
               random_sent++;
            end
         end
         phase++;
      end

      wait_idle();
      $display("Ran %0d requests over %0d register settings and four idling patterns",
               accepted_requests, config_settings);
      $display("Checked %0d stream results, %0d of them reporting a difference",
               results_checked, results_differing);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
